// ===== rtl/core/flvab_pkg.sv =====
// shared types and constants of the flv avc to annex-b converter
package flvab_pkg;

    typedef enum logic [1:0] {
        KIND_IDLE = 2'd0,
        KIND_HEAD = 2'd1,
        KIND_SEQ  = 2'd2,
        KIND_NALU = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        PH_VERSION  = 4'd0,
        PH_PROFILE  = 4'd1,
        PH_COMPAT   = 4'd2,
        PH_LEVEL    = 4'd3,
        PH_LEN_SIZE = 4'd4,
        PH_NUM_SPS  = 4'd5,
        PH_SPS_HI   = 4'd6,
        PH_SPS_LO   = 4'd7,
        PH_SPS_DATA = 4'd8,
        PH_NUM_PPS  = 4'd9,
        PH_PPS_HI   = 4'd10,
        PH_PPS_LO   = 4'd11,
        PH_PPS_DATA = 4'd12
    } phase_t;

    localparam logic [3:0] CODEC_AVC      = 4'h7;
    localparam logic [7:0] PKT_SEQ_HEADER = 8'h00;
    localparam logic [7:0] PKT_NALU       = 8'h01;
    localparam logic [2:0] HEADER_LEN     = 3'd5;
    localparam logic [7:0] START_CODE_END = 8'h01;

    // result slots of one command, emitted lowest first
    localparam int SLOT_LEAD       = 0;
    localparam int SLOT_SC0        = 1;
    localparam int SLOT_SC1        = 2;
    localparam int SLOT_SC2        = 3;
    localparam int SLOT_BODY       = 4;
    localparam int SLOT_FIN        = 5;
    localparam int SLOT_CLOSE_PS   = 6;
    localparam int SLOT_CLOSE_NALU = 7;
    localparam int NUM_SLOTS       = 8;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic                 lead_ps;
        logic                 body_ps;
        logic [7:0]           body_byte;
        logic [31:0]          stamp;
    } cmd_t;

endpackage

// ===== rtl/core/flvab_ifs.sv =====
// valid/ready channels for tag bytes in and annex-b beats out
interface flvab_in_if #(
    parameter int TAG_SIZE_BITS = 24
);
    logic                     valid;
    logic                     ready;
    logic [7:0]               in_byte;
    logic                     tag_start;
    logic [TAG_SIZE_BITS-1:0] bytes_after;
    logic [31:0]              stamp;

    modport source (output valid, in_byte, tag_start, bytes_after, stamp, input ready);
    modport sink (input valid, in_byte, tag_start, bytes_after, stamp, output ready);
endinterface

interface flvab_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        marker;
    logic        param_set;
    logic [31:0] out_stamp;
    logic        run_last;

    modport source (output valid, out_byte, marker, param_set, out_stamp, run_last,
                    input ready);
    modport sink (input valid, out_byte, marker, param_set, out_stamp, run_last,
                  output ready);
endinterface

// ===== rtl/core/flv_avc_to_annexb_converter_top.sv =====
// top level of the flv avc to annex-b converter
// Accepts one FLV video tag body byte per cycle on tag and delivers Annex-B beats on nal,
// one per cycle while nal is ready. The parser handles each byte and queues a command of
// up to five beats; the beat generator drains commands at that rate, so a byte that opens
// a NAL unit (start code, up to five beats) is absorbed by the four-entry command queue
// and input stalls only when the queue fills. Each accepted byte's command passes a queue
// entry and the output register before its first beat. A beat with marker set closes a
// decoder buffer; run_last flags the final beat caused by one input byte.
module flv_avc_to_annexb_converter_top #(
    parameter int TAG_SIZE_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    flvab_in_if.sink    tag,
    flvab_out_if.source nal
);

    logic            q_full;
    logic            q_push;
    flvab_pkg::cmd_t q_cmd;
    logic            q_pop;
    logic            q_valid;
    flvab_pkg::cmd_t q_head;

    flvab_front #(
        .TAG_SIZE_BITS(TAG_SIZE_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .tag    (tag),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (q_cmd)
    );

    flvab_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head)
    );

    flvab_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .nal     (nal)
    );

endmodule

// ===== rtl/core/flvab_front.sv =====
// front end: parses tag bytes and issues at most one result command per byte
module flvab_front #(
    parameter int TAG_SIZE_BITS = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    flvab_in_if.sink          tag,
    input  logic              q_full,
    output logic              q_push,
    output flvab_pkg::cmd_t   q_cmd
);

    localparam logic [31:0] BA_MASK = (TAG_SIZE_BITS >= 32) ? 32'hFFFF_FFFF :
                                      32'((64'd1 << TAG_SIZE_BITS) - 64'd1);

    flvab_pkg::kind_t  kind_reg, kind_next;
    flvab_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  header_pos_reg, header_pos_next;
    logic [2:0]  length_size_reg, length_size_next;
    logic [31:0] length_accum_reg, length_accum_next;
    logic [2:0]  length_seen_reg, length_seen_next;
    logic [31:0] unit_left_reg, unit_left_next;
    logic [4:0]  sps_left_reg, sps_left_next;
    logic [7:0]  pps_left_reg, pps_left_next;
    logic        skip_rest_reg, skip_rest_next;
    logic [31:0] held_stamp_reg, held_stamp_next;

    logic            accept;
    logic [31:0]     ba;
    logic [7:0]      b;
    logic [15:0]     len16;
    logic            fin;
    flvab_pkg::cmd_t cmd;

    assign tag.ready = !q_full;
    assign accept    = tag.valid && tag.ready;
    assign ba        = 32'(tag.bytes_after) & BA_MASK;
    assign b         = tag.in_byte;
    assign q_push    = accept && (cmd.mask != '0);
    assign q_cmd     = cmd;

    always_comb
    begin
        kind_next         = kind_reg;
        phase_next        = phase_reg;
        header_pos_next   = header_pos_reg;
        length_size_next  = length_size_reg;
        length_accum_next = length_accum_reg;
        length_seen_next  = length_seen_reg;
        unit_left_next    = unit_left_reg;
        sps_left_next     = sps_left_reg;
        pps_left_next     = pps_left_reg;
        skip_rest_next    = skip_rest_reg;
        held_stamp_next   = held_stamp_reg;
        cmd               = '0;
        len16             = '0;
        fin               = 1'b0;

        // close an open tag when a new one starts
        if (tag.tag_start)
        begin
            if (kind_reg == flvab_pkg::KIND_SEQ && !skip_rest_reg &&
                (phase_reg == flvab_pkg::PH_SPS_DATA || phase_reg == flvab_pkg::PH_PPS_DATA))
            begin
                cmd.mask[flvab_pkg::SLOT_LEAD] = 1'b1;
                cmd.lead_ps = 1'b1;
            end
            else if (kind_reg == flvab_pkg::KIND_NALU)
            begin
                cmd.mask[flvab_pkg::SLOT_LEAD] = 1'b1;
                cmd.lead_ps = 1'b0;
            end
            kind_next         = (ba < 32'd4) ? flvab_pkg::KIND_IDLE : flvab_pkg::KIND_HEAD;
            header_pos_next   = '0;
            skip_rest_next    = 1'b0;
            phase_next        = flvab_pkg::PH_VERSION;
            length_accum_next = '0;
            length_seen_next  = '0;
            unit_left_next    = '0;
            sps_left_next     = '0;
            pps_left_next     = '0;
            held_stamp_next   = tag.stamp;
        end

        if (kind_next != flvab_pkg::KIND_IDLE)
        begin
            if (header_pos_next < flvab_pkg::HEADER_LEN)
            begin
                if (header_pos_next == 3'd0 && b[3:0] != flvab_pkg::CODEC_AVC)
                begin
                    kind_next = flvab_pkg::KIND_IDLE;
                end
                else if (header_pos_next == 3'd1)
                begin
                    if (b == flvab_pkg::PKT_SEQ_HEADER)
                    begin
                        kind_next = flvab_pkg::KIND_SEQ;
                    end
                    else if (b == flvab_pkg::PKT_NALU)
                    begin
                        kind_next = flvab_pkg::KIND_NALU;
                    end
                    else
                    begin
                        kind_next = flvab_pkg::KIND_IDLE;
                    end
                end
                header_pos_next = header_pos_next + 3'd1;
            end
            else if (kind_next == flvab_pkg::KIND_SEQ && !skip_rest_next)
            begin
                case (phase_next)
                    flvab_pkg::PH_VERSION, flvab_pkg::PH_PROFILE, flvab_pkg::PH_COMPAT,
                    flvab_pkg::PH_LEVEL, flvab_pkg::PH_LEN_SIZE:
                    begin
                        if (phase_next == flvab_pkg::PH_VERSION && ba < 32'd6)
                        begin
                            skip_rest_next = 1'b1;
                        end
                        else
                        begin
                            if (phase_next == flvab_pkg::PH_LEN_SIZE)
                            begin
                                length_size_next = {1'b0, b[1:0]} + 3'd1;
                            end
                            phase_next = flvab_pkg::phase_t'(phase_next + 4'd1);
                        end
                    end
                    flvab_pkg::PH_NUM_SPS:
                    begin
                        sps_left_next = b[4:0];
                        phase_next = (b[4:0] != '0) ? flvab_pkg::PH_SPS_HI
                                                    : flvab_pkg::PH_NUM_PPS;
                    end
                    flvab_pkg::PH_SPS_HI, flvab_pkg::PH_PPS_HI:
                    begin
                        if (ba == '0)
                        begin
                            skip_rest_next = 1'b1;
                        end
                        else
                        begin
                            length_accum_next = {24'd0, b};
                            phase_next = flvab_pkg::phase_t'(phase_next + 4'd1);
                        end
                    end
                    flvab_pkg::PH_SPS_LO, flvab_pkg::PH_PPS_LO:
                    begin
                        len16 = {length_accum_next[7:0], b};
                        length_accum_next = '0;
                        if (32'(len16) > ba)
                        begin
                            skip_rest_next = 1'b1;
                        end
                        else
                        begin
                            cmd.mask[flvab_pkg::SLOT_SC0]  = 1'b1;
                            cmd.mask[flvab_pkg::SLOT_SC1]  = 1'b1;
                            cmd.mask[flvab_pkg::SLOT_SC2]  = 1'b1;
                            cmd.mask[flvab_pkg::SLOT_BODY] = 1'b1;
                            cmd.body_byte = flvab_pkg::START_CODE_END;
                            cmd.body_ps   = 1'b1;
                            unit_left_next = 32'(len16);
                            if (len16 == '0)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                phase_next = flvab_pkg::phase_t'(phase_next + 4'd1);
                            end
                        end
                    end
                    flvab_pkg::PH_SPS_DATA, flvab_pkg::PH_PPS_DATA:
                    begin
                        cmd.mask[flvab_pkg::SLOT_BODY] = 1'b1;
                        cmd.body_byte = b;
                        cmd.body_ps   = 1'b1;
                        if (unit_left_next != '0)
                        begin
                            unit_left_next = unit_left_next - 32'd1;
                        end
                        if (unit_left_next == '0)
                        begin
                            fin = 1'b1;
                        end
                    end
                    flvab_pkg::PH_NUM_PPS:
                    begin
                        pps_left_next = b;
                        if (b != '0)
                        begin
                            phase_next = flvab_pkg::PH_PPS_HI;
                        end
                        else
                        begin
                            skip_rest_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        skip_rest_next = 1'b1;
                    end
                endcase

                // end of one parameter set
                if (fin)
                begin
                    cmd.mask[flvab_pkg::SLOT_FIN] = 1'b1;
                    if (phase_next <= flvab_pkg::PH_SPS_DATA)
                    begin
                        if (sps_left_next != '0)
                        begin
                            sps_left_next = sps_left_next - 5'd1;
                        end
                        phase_next = (sps_left_next != '0) ? flvab_pkg::PH_SPS_HI
                                                           : flvab_pkg::PH_NUM_PPS;
                    end
                    else
                    begin
                        if (pps_left_next != '0)
                        begin
                            pps_left_next = pps_left_next - 8'd1;
                        end
                        if (pps_left_next != '0)
                        begin
                            phase_next = flvab_pkg::PH_PPS_HI;
                        end
                        else
                        begin
                            skip_rest_next = 1'b1;
                        end
                    end
                end
            end
            else if (kind_next == flvab_pkg::KIND_NALU && !skip_rest_next)
            begin
                if (unit_left_next != '0)
                begin
                    cmd.mask[flvab_pkg::SLOT_BODY] = 1'b1;
                    cmd.body_byte = b;
                    unit_left_next = unit_left_next - 32'd1;
                end
                else if (length_seen_next == '0 &&
                         ba < 32'(length_size_next - 3'd1))
                begin
                    skip_rest_next = 1'b1;
                end
                else
                begin
                    length_accum_next = {length_accum_next[23:0], b};
                    length_seen_next  = length_seen_next + 3'd1;
                    if (length_seen_next >= length_size_next)
                    begin
                        length_seen_next = '0;
                        if (length_accum_next > ba)
                        begin
                            skip_rest_next = 1'b1;
                        end
                        else
                        begin
                            cmd.mask[flvab_pkg::SLOT_SC0]  = 1'b1;
                            cmd.mask[flvab_pkg::SLOT_SC1]  = 1'b1;
                            cmd.mask[flvab_pkg::SLOT_SC2]  = 1'b1;
                            cmd.mask[flvab_pkg::SLOT_BODY] = 1'b1;
                            cmd.body_byte  = flvab_pkg::START_CODE_END;
                            unit_left_next = length_accum_next;
                        end
                        length_accum_next = '0;
                    end
                end
            end

            // last byte of the tag
            if (ba == '0 && kind_next != flvab_pkg::KIND_IDLE)
            begin
                if (kind_next == flvab_pkg::KIND_SEQ && !skip_rest_next &&
                    (phase_next == flvab_pkg::PH_SPS_DATA ||
                     phase_next == flvab_pkg::PH_PPS_DATA))
                begin
                    cmd.mask[flvab_pkg::SLOT_CLOSE_PS] = 1'b1;
                end
                if (kind_next == flvab_pkg::KIND_NALU)
                begin
                    cmd.mask[flvab_pkg::SLOT_CLOSE_NALU] = 1'b1;
                end
                kind_next = flvab_pkg::KIND_IDLE;
            end
        end

        cmd.stamp = cmd.mask[flvab_pkg::SLOT_LEAD] ? held_stamp_reg : held_stamp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg         <= flvab_pkg::KIND_IDLE;
            phase_reg        <= flvab_pkg::PH_VERSION;
            header_pos_reg   <= '0;
            length_size_reg  <= 3'd4;
            length_accum_reg <= '0;
            length_seen_reg  <= '0;
            unit_left_reg    <= '0;
            sps_left_reg     <= '0;
            pps_left_reg     <= '0;
            skip_rest_reg    <= 1'b0;
            held_stamp_reg   <= '0;
        end
        else if (accept)
        begin
            kind_reg         <= kind_next;
            phase_reg        <= phase_next;
            header_pos_reg   <= header_pos_next;
            length_size_reg  <= length_size_next;
            length_accum_reg <= length_accum_next;
            length_seen_reg  <= length_seen_next;
            unit_left_reg    <= unit_left_next;
            sps_left_reg     <= sps_left_next;
            pps_left_reg     <= pps_left_next;
            skip_rest_reg    <= skip_rest_next;
            held_stamp_reg   <= held_stamp_next;
        end
    end

endmodule

// ===== rtl/core/flvab_queue.sv =====
// short command queue between the parser and the beat generator
module flvab_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  flvab_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output flvab_pkg::cmd_t head_cmd
);

    localparam int PTR_W = $clog2(flvab_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W:0] DEPTH_CNT = (PTR_W + 1)'(flvab_pkg::QUEUE_DEPTH);

    flvab_pkg::cmd_t  mem [flvab_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign full       = (count_reg == DEPTH_CNT);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

// ===== rtl/core/flvab_back.sv =====
// back end: expands commands into output beats, one per cycle while the output is not stalled
module flvab_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  flvab_pkg::cmd_t q_head,
    output logic            q_pop,
    flvab_out_if.source     nal
);

    flvab_pkg::cmd_t             cmd_reg;
    logic [flvab_pkg::NUM_SLOTS-1:0] mask_reg, mask_next;
    logic                        valid_reg, valid_next;
    logic [7:0]                  byte_reg;
    logic                        marker_reg;
    logic                        ps_reg;
    logic [31:0]                 stamp_reg;
    logic                        last_reg;

    logic                        have_cur;
    flvab_pkg::cmd_t             src;
    logic [flvab_pkg::NUM_SLOTS-1:0] src_mask, low, rest;
    logic                        adv, emit;
    logic [$clog2(flvab_pkg::NUM_SLOTS)-1:0] slot;
    logic [7:0]                  beat_byte;
    logic                        beat_marker, beat_ps;

    assign have_cur = (mask_reg != '0);
    assign src      = have_cur ? cmd_reg : q_head;
    assign src_mask = have_cur ? mask_reg : (q_valid ? q_head.mask : '0);
    assign low      = src_mask & (~src_mask + 1'b1);
    assign rest     = src_mask & ~low;
    assign adv      = !valid_reg || nal.ready;
    assign emit     = adv && (src_mask != '0);
    assign q_pop    = emit && !have_cur;

    always_comb
    begin
        slot = '0;
        for (int i = 0; i < flvab_pkg::NUM_SLOTS; i++)
        begin
            if (low[i])
            begin
                slot = ($clog2(flvab_pkg::NUM_SLOTS))'(i);
            end
        end
    end

    always_comb
    begin
        beat_byte   = '0;
        beat_marker = 1'b0;
        beat_ps     = 1'b0;
        case (int'(slot))
            flvab_pkg::SLOT_LEAD:
            begin
                beat_marker = 1'b1;
                beat_ps     = src.lead_ps;
            end
            flvab_pkg::SLOT_SC0, flvab_pkg::SLOT_SC1, flvab_pkg::SLOT_SC2:
            begin
                beat_ps = src.body_ps;
            end
            flvab_pkg::SLOT_BODY:
            begin
                beat_byte = src.body_byte;
                beat_ps   = src.body_ps;
            end
            flvab_pkg::SLOT_FIN, flvab_pkg::SLOT_CLOSE_PS:
            begin
                beat_marker = 1'b1;
                beat_ps     = 1'b1;
            end
            default:
            begin
                beat_marker = 1'b1;
                beat_ps     = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        mask_next  = emit ? rest : mask_reg;
        valid_next = emit ? 1'b1 : (nal.ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg  <= mask_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_head;
        end
        if (emit)
        begin
            byte_reg   <= beat_byte;
            marker_reg <= beat_marker;
            ps_reg     <= beat_ps;
            stamp_reg  <= beat_ps ? '0 : src.stamp;
            last_reg   <= (rest == '0);
        end
    end

    assign nal.valid     = valid_reg;
    assign nal.out_byte  = byte_reg;
    assign nal.marker    = marker_reg;
    assign nal.param_set = ps_reg;
    assign nal.out_stamp = stamp_reg;
    assign nal.run_last  = last_reg;

    a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        have_cur |-> !q_pop)
        else $error("queue popped while a command is still expanding");

    a_emit_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> valid_reg)
        else $error("beat emitted but output register empty");

    a_last_ends_command: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && rest == '0) |=> (mask_reg == '0))
        else $error("command left pending after its last beat");

endmodule
